// ----- hw/rtl/lr_pkg.sv -----
// Shared constants for the line rasterizer and its checker.
package lr_pkg;

    // Default coordinate width and fixed field widths.
    localparam int COORD_BITS_DEFAULT = 12;
    localparam int SIZE_W             = 11;
    localparam int INDEX_W            = 20;
    localparam int WORD_W             = 16;
    localparam int CFG_INDEX_W        = 2;

    // Register indexes on the configuration channel.
    localparam logic [CFG_INDEX_W-1:0] REG_DISP_COLS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DISP_ROWS = 2'd1;

    // Register reset values.
    localparam logic [SIZE_W-1:0] DISP_COLS_RESET = 11'd120;
    localparam logic [SIZE_W-1:0] DISP_ROWS_RESET = 11'd40;

    // Operation codes carried in the input tuser bit.
    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK  = 1'b1;

endpackage

// ----- hw/rtl/line_rasterizer.sv -----
// Bresenham line stepper: start transfers load a line, tick transfers emit one pixel each while a line is in progress.
// A productive tick's pixel is registered and shows on m_tvalid in the cycle after its transfer.
// Throughput: one input transfer per cycle while s_tready is high; step, clip and index multiply-add are combinational.
// s_tready stays high while the output register is empty or being drained.
// Reset (aresetn low, synchronous) idles the stepper, empties the output register and
// restores the 120 by 40 screen size; no clearing pass is needed.
module line_rasterizer #(
    parameter int COORD_BITS = lr_pkg::COORD_BITS_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Input stream.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // tdata from bit 0: start_x, start_y, end_x, end_y, glyph, attribute, zero fill.
    input  logic [((4*COORD_BITS+2*lr_pkg::WORD_W+7)/8)*8-1:0] s_tdata,
    // tuser: operation.
    input  logic                                s_tuser,
    // Result stream.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // tdata from bit 0: pixel_x, pixel_y, buffer_index, out_glyph, out_attribute, zero fill.
    output logic [((2*COORD_BITS+lr_pkg::INDEX_W+2*lr_pkg::WORD_W+7)/8)*8-1:0] m_tdata,
    // tuser: visible.
    output logic                                m_tuser,
    output logic                                m_tlast,
    // Configuration write channel.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lr_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [lr_pkg::SIZE_W-1:0]           cfg_data
);
    import lr_pkg::*;

    localparam int C          = COORD_BITS;
    localparam int OUT_W      = 2*C + INDEX_W + 2*WORD_W;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;
    localparam int CMP_W      = (C > SIZE_W) ? C : SIZE_W;

    // Configuration registers.
    logic [SIZE_W-1:0] disp_cols_reg;
    logic [SIZE_W-1:0] disp_rows_reg;

    // Stepper state.
    logic signed [C-1:0] cur_x_reg, cur_y_reg, target_x_reg, target_y_reg;
    logic signed [1:0]   dir_x_reg, dir_y_reg;
    logic [C-1:0]        span_x_reg, span_y_reg;
    logic signed [C:0]   err_acc_reg;
    logic                x_major_reg;
    logic                busy_reg;
    logic [WORD_W-1:0]   held_glyph_reg, held_attribute_reg;

    // Output register.
    logic                m_valid_reg;
    logic signed [C-1:0] out_x_reg, out_y_reg;
    logic                out_visible_reg;
    logic [INDEX_W-1:0]  out_index_reg;
    logic [WORD_W-1:0]   out_glyph_reg, out_attribute_reg;
    logic                out_last_reg;

    // Input field unpacking.
    logic signed [C-1:0] in_start_x, in_start_y, in_end_x, in_end_y;
    logic [WORD_W-1:0]   in_glyph, in_attribute;

    assign in_start_x   = s_tdata[C-1:0];
    assign in_start_y   = s_tdata[2*C-1:C];
    assign in_end_x     = s_tdata[3*C-1:2*C];
    assign in_end_y     = s_tdata[4*C-1:3*C];
    assign in_glyph     = s_tdata[4*C+WORD_W-1:4*C];
    assign in_attribute = s_tdata[4*C+2*WORD_W-1:4*C+WORD_W];

    // Handshakes. The output register parts the two sides.
    logic s_accept, do_start, do_pixel;

    assign s_tready  = !m_valid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;
    assign do_start  = s_accept && (s_tuser == OP_START);
    assign do_pixel  = s_accept && (s_tuser == OP_TICK) && busy_reg;
    assign cfg_ready = 1'b1;

    // Line setup: deltas, directions, spans and the initial error term.
    logic signed [C:0] dx, dy;
    logic [C-1:0]      abs_dx, abs_dy, setup_major;
    logic signed [1:0] setup_dir_x, setup_dir_y;
    logic              setup_x_major;

    always_comb begin
        dx = {in_end_x[C-1], in_end_x} - {in_start_x[C-1], in_start_x};
        dy = {in_end_y[C-1], in_end_y} - {in_start_y[C-1], in_start_y};
        abs_dx = dx[C] ? C'(-dx) : C'(dx);
        abs_dy = dy[C] ? C'(-dy) : C'(dy);
        setup_dir_x = dx[C] ? 2'sb11 : ((dx != '0) ? 2'sb01 : 2'sb00);
        setup_dir_y = dy[C] ? 2'sb11 : ((dy != '0) ? 2'sb01 : 2'sb00);
        setup_x_major = abs_dx > abs_dy;
        setup_major = setup_x_major ? abs_dx : abs_dy;
    end

    // One Bresenham step from the current state.
    logic signed [C-1:0] step_x, step_y;
    logic signed [C-1:0] next_x, next_y;
    logic signed [C:0]   err_sub, err_next;
    logic [C-1:0]        minor_span, major_span;
    logic                step_last;

    always_comb begin
        step_x = {{(C-2){dir_x_reg[1]}}, dir_x_reg};
        step_y = {{(C-2){dir_y_reg[1]}}, dir_y_reg};
        minor_span = x_major_reg ? span_y_reg : span_x_reg;
        major_span = x_major_reg ? span_x_reg : span_y_reg;
        err_sub = err_acc_reg - $signed({1'b0, minor_span});
        err_next = err_sub;
        next_x = cur_x_reg;
        next_y = cur_y_reg;
        if (err_sub[C]) begin
            err_next = err_sub + $signed({1'b0, major_span});
        end
        if (x_major_reg) begin
            next_x = cur_x_reg + step_x;
            if (err_sub[C]) begin
                next_y = cur_y_reg + step_y;
            end
            step_last = (next_x == target_x_reg);
        end else begin
            next_y = cur_y_reg + step_y;
            if (err_sub[C]) begin
                next_x = cur_x_reg + step_x;
            end
            step_last = (next_y == target_y_reg);
        end
    end

    // Clip test and row-major index for the pixel being emitted.
    logic [CMP_W-1:0]   px_cmp, py_cmp;
    logic               pix_visible;
    logic [INDEX_W-1:0] pix_index;

    always_comb begin
        px_cmp = CMP_W'($unsigned(cur_x_reg));
        py_cmp = CMP_W'($unsigned(cur_y_reg));
        pix_visible = !cur_x_reg[C-1] && !cur_y_reg[C-1] &&
                      (px_cmp < CMP_W'(disp_cols_reg)) &&
                      (py_cmp < CMP_W'(disp_rows_reg));
        pix_index = '0;
        if (pix_visible) begin
            pix_index = INDEX_W'($unsigned(cur_y_reg)) * INDEX_W'(disp_cols_reg)
                      + INDEX_W'($unsigned(cur_x_reg));
        end
    end

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            disp_cols_reg <= DISP_COLS_RESET;
            disp_rows_reg <= DISP_ROWS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_DISP_COLS: disp_cols_reg <= cfg_data;
                REG_DISP_ROWS: disp_rows_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Stepper control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (do_start) begin
            busy_reg <= (setup_major != '0);
        end else if (do_pixel && step_last) begin
            busy_reg <= 1'b0;
        end
    end

    // Stepper datapath.
    always_ff @(posedge aclk) begin
        if (do_start) begin
            cur_x_reg          <= in_start_x;
            cur_y_reg          <= in_start_y;
            target_x_reg       <= in_end_x;
            target_y_reg       <= in_end_y;
            dir_x_reg          <= setup_dir_x;
            dir_y_reg          <= setup_dir_y;
            span_x_reg         <= abs_dx;
            span_y_reg         <= abs_dy;
            x_major_reg        <= setup_x_major;
            err_acc_reg        <= $signed({2'b00, setup_major[C-1:1]});
            held_glyph_reg     <= in_glyph;
            held_attribute_reg <= in_attribute;
        end else if (do_pixel) begin
            cur_x_reg   <= next_x;
            cur_y_reg   <= next_y;
            err_acc_reg <= err_next;
        end
    end

    // Output valid: loaded by a productive tick, cleared once the transfer completes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= do_pixel;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge aclk) begin
        if (do_pixel) begin
            out_x_reg         <= cur_x_reg;
            out_y_reg         <= cur_y_reg;
            out_visible_reg   <= pix_visible;
            out_index_reg     <= pix_index;
            out_glyph_reg     <= held_glyph_reg;
            out_attribute_reg <= held_attribute_reg;
            out_last_reg      <= step_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_TDATA_W'({out_attribute_reg, out_glyph_reg, out_index_reg,
                                    out_y_reg, out_x_reg});
    assign m_tuser  = out_visible_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ----- hw/rtl/line_rasterizer_checker.sv -----
// Port-level assertions for the line rasterizer, bound to the top level.
module line_rasterizer_checker #(
    parameter int COORD_BITS = lr_pkg::COORD_BITS_DEFAULT
) (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic                                s_tuser,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [((2*COORD_BITS+lr_pkg::INDEX_W+2*lr_pkg::WORD_W+7)/8)*8-1:0] m_tdata,
    input logic                                m_tuser,
    input logic                                m_tlast
);
    import lr_pkg::*;

    localparam int C = COORD_BITS;

    // A stalled result holds its payload.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                                  && $stable(m_tuser))
        else $error("stalled result changed");

    // Input is taken whenever the output register is empty or draining.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("s_tready does not follow the output register");

    // A start transfer never produces a result.
    a_start_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == OP_START) && !(m_tvalid && !m_tready)
        |=> !m_tvalid)
        else $error("start transfer produced a result");

    // Hidden pixels carry a zero index.
    a_hidden_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[2*C+INDEX_W-1:2*C] == '0)
        else $error("off-screen pixel with nonzero index");

    // Visible pixels have nonnegative coordinates.
    a_visible_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> !m_tdata[C-1] && !m_tdata[2*C-1])
        else $error("visible pixel with negative coordinate");

endmodule

bind line_rasterizer line_rasterizer_checker #(.COORD_BITS(COORD_BITS)) u_checker (.*);
